// ===== rtl/core/sas_pkg.sv =====
`timescale 1ns / 1ps

package sas_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SORT   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

// ===== rtl/core/sas_chan_if.sv =====
`timescale 1ns / 1ps

interface sas_req_if;
  logic                               valid;
  logic                               ready;
  logic [sas_pkg::FUNC_W-1:0]         func;
  logic signed [sas_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface sas_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [sas_pkg::STATUS_W-1:0]       status;
  logic signed [sas_pkg::VALUE_W-1:0] value_res;
  logic [sas_pkg::POS_W-1:0]          position;
  logic                               last;

  modport source (output valid, output status, output value_res, output position,
                  output last, input ready);
  modport sink (input valid, input status, input value_res, input position,
                input last, output ready);
endinterface

// ===== rtl/core/sas_ram.sv =====
`timescale 1ns / 1ps

module sas_ram #(
  parameter int WIDTH = sas_pkg::VALUE_W,
  parameter int DEPTH = sas_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sortable_array_store.sv =====
`timescale 1ns / 1ps

// Bounded store of signed 32-bit values with insert, remove, ascending sort and
// read out; the elements live in one memory with a registered read. Insert
// writes its slot directly; remove, sort and read out walk the memory through
// a single read port, taking one item at a time. Remove searches, then closes
// the gap while streaming; sort runs bubble passes, each streaming the unsorted
// part, then writing back the carried maximum; read out fetches each element
// only once the output register is free for it. A new item is taken while the
// previous result still waits on the output register. Insert into a full store
// reports full and changes nothing; remove reports not found when no element
// matches.
module sortable_array_store #(
  parameter int CAPACITY = sas_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  sas_req_if.sink   req,
  sas_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_SHIFT   = 3'd2;
  localparam logic [2:0] S_SORT    = 3'd3;
  localparam logic [2:0] S_SORT_WB = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;
  localparam logic [2:0] S_DUMP    = 3'd6;

  logic [2:0]                         state;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      ptr;
  logic [AW-1:0]                      idx_d;
  logic                               vld_d;
  logic [AW-1:0]                      lim;
  logic signed [sas_pkg::VALUE_W-1:0] value_q;
  logic signed [sas_pkg::VALUE_W-1:0] carry;
  logic [sas_pkg::STATUS_W-1:0]       res_status;

  logic                               out_valid;
  logic [sas_pkg::STATUS_W-1:0]       out_status;
  logic signed [sas_pkg::VALUE_W-1:0] out_value;
  logic [sas_pkg::POS_W-1:0]          out_position;
  logic                               out_last;

  logic                         rd_en;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [sas_pkg::VALUE_W-1:0]  wr_data;
  logic [sas_pkg::VALUE_W-1:0]  rdata;
  logic                         accept;
  logic                         out_free;
  logic                         out_load;
  logic                         gt;
  logic                         is_last;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign out_load = (state == S_RESP && out_free) || (state == S_DUMP && vld_d);
  assign gt       = carry > $signed(rdata);
  assign is_last  = (CW'(idx_d) + CW'(1)) == count;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.value_res = out_value;
  assign rsp.position  = out_position;
  assign rsp.last      = out_last;

  sas_ram #(
    .WIDTH (sas_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ptr[AW-1:0]),
    .rd_data (rdata)
  );

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = carry;
    case (state)
      S_IDLE: begin
        if (accept && req.func == sas_pkg::FN_INSERT && count != CW'(CAPACITY)) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_data = req.value;
        end
      end
      S_SEARCH: begin
        rd_en = ptr < count;
      end
      S_SHIFT: begin
        rd_en = ptr < count;
        // move each later element one place down
        if (vld_d) begin
          wr_en   = 1'b1;
          wr_addr = idx_d - AW'(1);
          wr_data = rdata;
        end
      end
      S_SORT: begin
        rd_en = ptr <= CW'(lim);
        // keep the larger one in carry, drop the smaller one behind it
        if (vld_d && idx_d != '0) begin
          wr_en   = 1'b1;
          wr_addr = idx_d - AW'(1);
          wr_data = gt ? rdata : carry;
        end
      end
      S_SORT_WB: begin
        wr_en   = 1'b1;
        wr_addr = lim;
        wr_data = carry;
      end
      S_DUMP: begin
        rd_en = (ptr < count) && !vld_d && out_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      vld_d     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_d <= rd_en;
      if (rd_en) begin
        idx_d <= ptr[AW-1:0];
        ptr   <= ptr + CW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            value_q <= req.value;
            ptr     <= '0;
            case (req.func)
              sas_pkg::FN_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  res_status <= sas_pkg::ST_FULL;
                end else begin
                  count      <= count + CW'(1);
                  res_status <= sas_pkg::ST_OK;
                end
                state <= S_RESP;
              end
              sas_pkg::FN_REMOVE: begin
                state <= S_SEARCH;
              end
              sas_pkg::FN_SORT: begin
                res_status <= sas_pkg::ST_OK;
                if (count < CW'(2)) begin
                  state <= S_RESP;
                end else begin
                  lim   <= AW'(count - CW'(1));
                  state <= S_SORT;
                end
              end
              default: begin
                if (count == '0) begin
                  res_status <= sas_pkg::ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  state <= S_DUMP;
                end
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (vld_d && rdata == value_q) begin
            state <= S_SHIFT;
          end else if (!vld_d && ptr >= count) begin
            res_status <= sas_pkg::ST_NOT_FOUND;
            state      <= S_RESP;
          end
        end
        S_SHIFT: begin
          if (!vld_d && ptr >= count) begin
            count      <= count - CW'(1);
            res_status <= sas_pkg::ST_OK;
            state      <= S_RESP;
          end
        end
        S_SORT: begin
          if (vld_d) begin
            if (idx_d == '0 || !gt) begin
              carry <= rdata;
            end
            if (idx_d == lim) begin
              state <= S_SORT_WB;
            end
          end
        end
        S_SORT_WB: begin
          if (lim == AW'(1)) begin
            state <= S_RESP;
          end else begin
            lim   <= lim - AW'(1);
            ptr   <= '0;
            state <= S_SORT;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_status   <= res_status;
            out_value    <= '0;
            out_position <= '0;
            out_last     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_DUMP: begin
          // a read is issued only when the output register will be free
          if (vld_d) begin
            out_status   <= sas_pkg::ST_ELEMENT;
            out_value    <= rdata;
            out_position <= sas_pkg::POS_W'(idx_d);
            out_last     <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sas_checker.sv =====
`timescale 1ns / 1ps

module sas_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [sas_pkg::STATUS_W-1:0]       rsp_status,
  input logic signed [sas_pkg::VALUE_W-1:0] rsp_value_res,
  input logic [sas_pkg::POS_W-1:0]          rsp_position,
  input logic                               rsp_last
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_value_res) && $stable(rsp_position) && $stable(rsp_last))
    else $error("stalled result changed");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != sas_pkg::ST_ELEMENT |->
      rsp_last && rsp_value_res == '0 && rsp_position == '0)
    else $error("non-element result not a clean single transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken again right after a transfer");

  a_readout_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && rsp_status == sas_pkg::ST_ELEMENT && !rsp_last
      |=> !req_ready)
    else $error("input taken in the middle of a read out");

endmodule

bind sortable_array_store sas_checker u_sas_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_value_res (rsp.value_res),
  .rsp_position  (rsp.position),
  .rsp_last      (rsp.last)
);

// ===== tb/sortable_array_store_checker.sv =====
`timescale 1ns / 1ps

module sortable_array_store_checker (
  input  logic clk,
  input  logic rst,
  sas_req_if   req,
  sas_rsp_if   rsp,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [sas_pkg::STATUS_W-1:0]       status;
    logic signed [sas_pkg::VALUE_W-1:0] value_res;
    logic [sas_pkg::POS_W-1:0]          position;
    logic                               last;
  } store_result_t;

  logic signed [sas_pkg::VALUE_W-1:0] element_model [sas_pkg::CAPACITY_DEF];
  int                                 count_model;
  store_result_t                      results_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic store_result_t plain_result(input logic [sas_pkg::STATUS_W-1:0] st);
    store_result_t r;
    r.status    = st;
    r.value_res = '0;
    r.position  = '0;
    r.last      = 1'b1;
    return r;
  endfunction

  // Apply one operation to the shadow store and queue the results it causes.
  function automatic void apply_store_op(input logic [sas_pkg::FUNC_W-1:0] fn,
                                         input logic signed [sas_pkg::VALUE_W-1:0] val);
    store_result_t                      r;
    int                                 hit;
    logic signed [sas_pkg::VALUE_W-1:0] t;
    r = plain_result(sas_pkg::ST_OK);
    case (fn)
      sas_pkg::FN_INSERT: begin
        if (count_model >= sas_pkg::CAPACITY_DEF) begin
          r.status = sas_pkg::ST_FULL;
        end else begin
          element_model[count_model] = val;
          count_model++;
        end
      end
      sas_pkg::FN_REMOVE: begin
        hit = -1;
        for (int i = 0; i < count_model; i++)
          if (hit < 0 && element_model[i] == val) hit = i;
        if (hit < 0) begin
          r.status = sas_pkg::ST_NOT_FOUND;
        end else begin
          // close the gap left by the removed element
          for (int j = hit; j + 1 < count_model; j++)
            element_model[j] = element_model[j+1];
          count_model--;
        end
      end
      sas_pkg::FN_SORT: begin
        for (int i = 0; i + 1 < count_model; i++)
          for (int j = 0; j + 1 < count_model - i; j++)
            if (element_model[j] > element_model[j+1]) begin
              t                  = element_model[j];
              element_model[j]   = element_model[j+1];
              element_model[j+1] = t;
            end
      end
      default: begin
        if (count_model == 0) begin
          r.status = sas_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < count_model; i++) begin
            r.status    = sas_pkg::ST_ELEMENT;
            r.value_res = element_model[i];
            r.position  = sas_pkg::POS_W'(i);
            r.last      = (i == count_model - 1);
            results_due.push_back(r);
          end
          return;
        end
      end
    endcase
    results_due.push_back(r);
  endfunction

  task automatic note_mismatch(input string what, input store_result_t want,
                               input store_result_t seen);
    errors++;
    if (errors <= 10)
      $display({"%0t mismatch (%s): expected status=%0d value=%0d pos=%0d last=%0b,",
                " got status=%0d value=%0d pos=%0d last=%0b"},
               $realtime, what, want.status, want.value_res, want.position, want.last,
               seen.status, seen.value_res, seen.position, seen.last);
  endtask

  always @(posedge clk) begin : watch
    store_result_t seen;
    store_result_t want;
    if (rst) begin
      count_model = 0;
      results_due.delete();
    end else begin
      // a result never belongs to a request taken at the same edge
      if (rsp.valid && rsp.ready) begin
        seen.status    = rsp.status;
        seen.value_res = rsp.value_res;
        seen.position  = rsp.position;
        seen.last      = rsp.last;
        if (results_due.size() == 0) begin
          want = '0;
          note_mismatch("unexpected result", want, seen);
        end else begin
          want = results_due.pop_front();
          if (seen.status !== want.status || seen.value_res !== want.value_res ||
              seen.position !== want.position || seen.last !== want.last)
            note_mismatch("field", want, seen);
        end
      end
      if (req.valid && req.ready)
        apply_store_op(req.func, req.value);
    end
    pending <= results_due.size();
  end

  final begin
    if (results_due.size() != 0 && errors <= 10)
      $display("%0d results never arrived", results_due.size());
  end

endmodule

// ===== tb/sortable_array_store_test.sv =====
`timescale 1ns / 1ps

module sortable_array_store_test;

  logic clk;
  logic rst;
  int   fail_count;
  int   open_count;
  bit   quiet;

  logic signed [sas_pkg::VALUE_W-1:0] held_values [$];

  sas_req_if req_ch ();
  sas_rsp_if rsp_ch ();

  sortable_array_store i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sortable_array_store_checker i_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (fail_count),
    .pending (open_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAIL sortable_array_store");
    $finish;
  end

  // Mix extremes, a small range that produces duplicates, and full random words.
  function automatic logic signed [sas_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      5:       return held_values.size() ? held_values[$urandom_range(0, held_values.size()-1)]
                                         : 32'($urandom);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic signed [sas_pkg::VALUE_W-1:0] pick_victim();
    if (held_values.size() != 0 && $urandom_range(0, 9) < 7)
      return held_values[$urandom_range(0, held_values.size()-1)];
    return pick_value();
  endfunction

  task automatic send_op(input logic [sas_pkg::FUNC_W-1:0] fn,
                         input logic signed [sas_pkg::VALUE_W-1:0] val);
    int hit;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= fn;
    req_ch.value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // track the multiset only to steer later removes toward stored values
    if (fn == sas_pkg::FN_INSERT && held_values.size() < sas_pkg::CAPACITY_DEF) begin
      held_values.push_back(val);
    end else if (fn == sas_pkg::FN_REMOVE) begin
      hit = -1;
      foreach (held_values[i])
        if (hit < 0 && held_values[i] == val) hit = i;
      if (hit >= 0) held_values.delete(hit);
    end
  endtask

  task automatic send_random_op(input int fill_bias);
    int roll;
    roll = $urandom_range(0, 99);
    if (held_values.size() > fill_bias) roll = roll + 20;
    if (roll < 45)
      send_op(sas_pkg::FN_INSERT, pick_value());
    else if (roll < 80)
      send_op(sas_pkg::FN_REMOVE, pick_victim());
    else if (roll < 95)
      send_op(sas_pkg::FN_READ, 32'($urandom));
    else
      send_op(sas_pkg::FN_SORT, 32'($urandom));
  endtask

  // Response side: random stall bursts, with long stretches of steady ready.
  initial begin
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet) begin
        if ($urandom_range(0, 7) == 0) begin
          rsp_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
          rsp_ch.ready <= 1'b1;
        end else if ($urandom_range(0, 30) == 0) begin
          repeat ($urandom_range(40, 100)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    quiet        = 1'b0;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func  <= sas_pkg::FN_INSERT;
    req_ch.value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, single element, extremes, duplicates
    send_op(sas_pkg::FN_READ, 32'sd0);
    send_op(sas_pkg::FN_SORT, 32'sd0);
    send_op(sas_pkg::FN_REMOVE, 32'sd0);
    send_op(sas_pkg::FN_INSERT, 32'sd7);
    send_op(sas_pkg::FN_SORT, 32'sd0);
    send_op(sas_pkg::FN_READ, 32'sh7FFF_FFFF);
    send_op(sas_pkg::FN_INSERT, 32'sh7FFF_FFFF);
    send_op(sas_pkg::FN_INSERT, 32'sh8000_0000);
    send_op(sas_pkg::FN_INSERT, -32'sd1);
    send_op(sas_pkg::FN_INSERT, 32'sd0);
    send_op(sas_pkg::FN_INSERT, 32'sd7);
    send_op(sas_pkg::FN_INSERT, 32'sd3);
    send_op(sas_pkg::FN_READ, 32'sh8000_0000);
    send_op(sas_pkg::FN_REMOVE, 32'sd7);
    send_op(sas_pkg::FN_REMOVE, 32'sd12345);
    send_op(sas_pkg::FN_REMOVE, 32'sh8000_0000);
    send_op(sas_pkg::FN_READ, -32'sd1);
    send_op(sas_pkg::FN_SORT, -32'sd1);
    send_op(sas_pkg::FN_READ, 32'sd0);
    send_op(sas_pkg::FN_REMOVE, 32'sh7FFF_FFFF);
    send_op(sas_pkg::FN_REMOVE, -32'sd1);
    send_op(sas_pkg::FN_READ, 32'sd0);

    // small store, mixed operations
    repeat (20) send_random_op(10);

    // fill to capacity, then push against the limit
    while (held_values.size() < sas_pkg::CAPACITY_DEF) begin
      if ($urandom_range(0, 15) == 0)
        send_op(sas_pkg::FN_REMOVE, pick_victim());
      else
        send_op(sas_pkg::FN_INSERT, pick_value());
    end
    send_op(sas_pkg::FN_INSERT, pick_value());
    send_op(sas_pkg::FN_INSERT, 32'($urandom));
    send_op(sas_pkg::FN_READ, 32'($urandom));
    send_op(sas_pkg::FN_REMOVE, pick_victim());
    send_op(sas_pkg::FN_INSERT, pick_value());
    send_op(sas_pkg::FN_INSERT, pick_value());
    send_op(sas_pkg::FN_SORT, 32'($urandom));
    send_op(sas_pkg::FN_READ, 32'($urandom));

    // drain back down; no idling in the last stretch
    repeat (15) begin
      if ($urandom_range(0, 5) == 0) send_random_op(0);
      else send_op(sas_pkg::FN_REMOVE, pick_victim());
    end
    quiet = 1'b1;
    repeat (12) send_random_op(8);
    send_op(sas_pkg::FN_SORT, 32'($urandom));
    send_op(sas_pkg::FN_READ, 32'($urandom));

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("PASS sortable_array_store");
    end else begin
      $display("FAIL sortable_array_store");
    end
    $finish;
  end

endmodule

// ===== sortable_array_store.f =====
rtl/core/sas_pkg.sv
rtl/core/sas_chan_if.sv
rtl/core/sas_ram.sv
rtl/core/sortable_array_store.sv
rtl/core/sas_checker.sv
tb/sortable_array_store_checker.sv
tb/sortable_array_store_test.sv
